// File: hw/rtl/tun_pkg.sv
// shared constants for the triangle unit normal block
package tun_pkg;

  // default vertex coordinate width
  localparam int COORD_WIDTH      = 16;
  // default fraction bits of the normal components
  localparam int NORMAL_FRAC_BITS = 14;
  // number of vector components
  localparam int NUM_AXES         = 3;

endpackage

// File: hw/rtl/tun_front.sv
// front pipeline: edges, cross product, squared length and scaled squares
module tun_front #(
  parameter int CW = tun_pkg::COORD_WIDTH,
  parameter int FB = tun_pkg::NORMAL_FRAC_BITS,
  parameter int SQW = 4 * CW + 4,
  parameter int SW  = SQW + 2,
  parameter int XW  = SQW + 2 * FB + 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_i,
  input  logic [CW-1:0]        ax,
  input  logic [CW-1:0]        ay,
  input  logic [CW-1:0]        az,
  input  logic [CW-1:0]        bx,
  input  logic [CW-1:0]        by_c,
  input  logic [CW-1:0]        bz,
  input  logic [CW-1:0]        cx,
  input  logic [CW-1:0]        cy,
  input  logic [CW-1:0]        cz,
  output logic                 v_o,
  output logic [SW-1:0]        s_o,
  output logic                 deg_o,
  output logic [2:0]           neg_o,
  output logic [2:0][XW-1:0]   r_o
);

  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int CMW = 2 * CW + 2;

  logic [2:0][EW-1:0]  e1_r, e2_r;
  logic [5:0][PW-1:0]  p_r;
  logic [2:0][CMW-1:0] m_r;
  logic [2:0]          neg3_r;
  logic [2:0][SQW-1:0] sq_r;
  logic [2:0]          neg4_r;
  logic [2:0][XW-1:0]  r_r;
  logic [SW-1:0]       s_r;
  logic                deg_r;
  logic [2:0]          neg5_r;
  logic [4:0]          v_r;

  logic [2:0][EW-1:0]  a_x, b_x, c_x;
  logic [2:0][PW:0]    cr;
  logic [SW-1:0]       s_nxt;

  // sign extend the vertices
  always_comb begin
    a_x[0] = {ax[CW-1], ax};
    a_x[1] = {ay[CW-1], ay};
    a_x[2] = {az[CW-1], az};
    b_x[0] = {bx[CW-1], bx};
    b_x[1] = {by_c[CW-1], by_c};
    b_x[2] = {bz[CW-1], bz};
    c_x[0] = {cx[CW-1], cx};
    c_x[1] = {cy[CW-1], cy};
    c_x[2] = {cz[CW-1], cz};
  end

  // cross product differences
  always_comb begin
    cr[0] = PW'(0) + {p_r[0][PW-1], p_r[0]} - {p_r[1][PW-1], p_r[1]};
    cr[1] = {p_r[2][PW-1], p_r[2]} - {p_r[3][PW-1], p_r[3]};
    cr[2] = {p_r[4][PW-1], p_r[4]} - {p_r[5][PW-1], p_r[5]};
  end

  // squared length
  assign s_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], v_i};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= a_x[i] - b_x[i];
        e2_r[i] <= b_x[i] - c_x[i];
      end
      p_r[0] <= PW'($signed(e1_r[1]) * $signed(e2_r[2]));
      p_r[1] <= PW'($signed(e1_r[2]) * $signed(e2_r[1]));
      p_r[2] <= PW'($signed(e1_r[2]) * $signed(e2_r[0]));
      p_r[3] <= PW'($signed(e1_r[0]) * $signed(e2_r[2]));
      p_r[4] <= PW'($signed(e1_r[0]) * $signed(e2_r[1]));
      p_r[5] <= PW'($signed(e1_r[1]) * $signed(e2_r[0]));
      for (int i = 0; i < 3; i++) begin
        neg3_r[i] <= cr[i][PW];
        m_r[i]    <= cr[i][PW] ? CMW'(-cr[i]) : CMW'(cr[i]);
        sq_r[i]   <= m_r[i] * m_r[i];
        r_r[i]    <= XW'(sq_r[i]) << (2 * FB + 2);
      end
      neg4_r <= neg3_r;
      neg5_r <= neg4_r;
      s_r    <= s_nxt;
      deg_r  <= (s_nxt == '0);
    end
  end

  assign v_o   = v_r[4];
  assign s_o   = s_r;
  assign deg_o = deg_r;
  assign neg_o = neg5_r;
  assign r_o   = r_r;

endmodule

// File: hw/rtl/tun_bit.sv
// one digit step of the rounded quotient for all three lanes
module tun_bit #(
  parameter int CW  = tun_pkg::COORD_WIDTH,
  parameter int FB  = tun_pkg::NORMAL_FRAC_BITS,
  parameter int BIT = 0,
  parameter int SQW = 4 * CW + 4,
  parameter int SW  = SQW + 2,
  parameter int XW  = SQW + 2 * FB + 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  logic [SW-1:0]      s_i,
  input  logic               deg_i,
  input  logic [2:0]         neg_i,
  input  logic [2:0][XW-1:0] e_i,
  input  logic [2:0][XW-1:0] f_i,
  input  logic [2:0][FB:0]   q_i,
  output logic               v_o,
  output logic [SW-1:0]      s_o,
  output logic               deg_o,
  output logic [2:0]         neg_o,
  output logic [2:0][XW-1:0] e_o,
  output logic [2:0][XW-1:0] f_o,
  output logic [2:0][FB:0]   q_o
);

  logic               v_r;
  logic [SW-1:0]      s_r;
  logic               deg_r;
  logic [2:0]         neg_r;
  logic [2:0][XW-1:0] e_r, f_r, e_nxt, f_nxt;
  logic [2:0][FB:0]   q_r, q_nxt;
  logic signed [XW-1:0] sx;

  assign sx = $signed(XW'(s_i));

  // residual test: R - (2q + 2^(b+1) - 1)^2 * s >= 0
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [XW-1:0] ev, fv, t;
      logic                 ok;
      ev = $signed(e_i[i]);
      fv = $signed(f_i[i]);
      t  = ev - (fv <<< (BIT + 2)) + (fv <<< 1) - (sx <<< (2 * BIT + 2))
           + (sx <<< (BIT + 2)) - sx;
      ok = !t[XW-1] && ((BIT == FB) || !q_i[i][FB]);
      e_nxt[i] = e_i[i];
      f_nxt[i] = f_i[i];
      q_nxt[i] = q_i[i];
      if (ok) begin
        q_nxt[i] = q_i[i] | ((FB+1)'(1) << BIT);
        e_nxt[i] = XW'(ev - (fv <<< (BIT + 2)) - (sx <<< (2 * BIT + 2)));
        f_nxt[i] = XW'(fv + (sx <<< (BIT + 1)));
      end
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= s_i;
      deg_r <= deg_i;
      neg_r <= neg_i;
      e_r   <= e_nxt;
      f_r   <= f_nxt;
      q_r   <= q_nxt;
    end
  end

  assign v_o   = v_r;
  assign s_o   = s_r;
  assign deg_o = deg_r;
  assign neg_o = neg_r;
  assign e_o   = e_r;
  assign f_o   = f_r;
  assign q_o   = q_r;

endmodule

// File: hw/rtl/triangle_unit_normal.sv
// top level of the triangle unit normal pipeline
//
// Takes one triangle per beat on the in_ channel (three vertices, signed
// fixed point) and returns one beat on the out_ channel: the negated unit
// face normal in signed fixed point with NORMAL_FRAC_BITS fraction bits,
// rounded to nearest, plus a degenerate flag for a zero cross product
// (then all components are zero).
// The pipeline has five front stages (edges, products, cross, squares,
// length), one stage per result bit of the quotient digit recurrence,
// and the output register.
// Throughput is one triangle per cycle while out_ready stays high.
// When the receiver stalls, the whole pipeline holds: in_ready drops
// while the output beat waits, and nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
module triangle_unit_normal #(
  parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_WIDTH-1:0]        in_ax,
  input  logic [COORD_WIDTH-1:0]        in_ay,
  input  logic [COORD_WIDTH-1:0]        in_az,
  input  logic [COORD_WIDTH-1:0]        in_bx,
  input  logic [COORD_WIDTH-1:0]        in_by_coord,
  input  logic [COORD_WIDTH-1:0]        in_bz,
  input  logic [COORD_WIDTH-1:0]        in_cx,
  input  logic [COORD_WIDTH-1:0]        in_cy,
  input  logic [COORD_WIDTH-1:0]        in_cz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [NORMAL_FRAC_BITS+1:0]   out_nx,
  output logic [NORMAL_FRAC_BITS+1:0]   out_ny,
  output logic [NORMAL_FRAC_BITS+1:0]   out_nz,
  output logic                          out_degenerate
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = NORMAL_FRAC_BITS;
  localparam int NW  = FB + 2;
  localparam int SQW = 4 * CW + 4;
  localparam int SW  = SQW + 2;
  localparam int XW  = SQW + 2 * FB + 6;
  localparam int NS  = FB + 2;

  logic en;

  // chain signals: index 0 is the front output, index FB+1 the last digit
  logic [NS-1:0]               v_c;
  logic [NS-1:0][SW-1:0]       s_c;
  logic [NS-1:0]               deg_c;
  logic [NS-1:0][2:0]          neg_c;
  logic [NS-1:0][2:0][XW-1:0]  e_c, f_c;
  logic [NS-1:0][2:0][FB:0]    q_c;

  logic                        out_v_r;
  logic [2:0][NW-1:0]          n_r;
  logic [2:0][NW-1:0]          n_nxt;
  logic                        deg_r;

  // whole pipeline advances unless the output beat is held
  assign en       = !out_v_r || out_ready;
  assign in_ready = en;

  tun_front #(.CW(CW), .FB(FB), .SQW(SQW), .SW(SW), .XW(XW)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (in_valid),
    .ax    (in_ax),
    .ay    (in_ay),
    .az    (in_az),
    .bx    (in_bx),
    .by_c  (in_by_coord),
    .bz    (in_bz),
    .cx    (in_cx),
    .cy    (in_cy),
    .cz    (in_cz),
    .v_o   (v_c[0]),
    .s_o   (s_c[0]),
    .deg_o (deg_c[0]),
    .neg_o (neg_c[0]),
    .r_o   (e_c[0])
  );

  assign f_c[0] = '0;
  assign q_c[0] = '0;

  // one stage per quotient bit, most significant first
  for (genvar k = 0; k <= FB; k++) begin : g_bit
    tun_bit #(.CW(CW), .FB(FB), .BIT(FB - k), .SQW(SQW), .SW(SW), .XW(XW)) u_bit (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (v_c[k]),
      .s_i   (s_c[k]),
      .deg_i (deg_c[k]),
      .neg_i (neg_c[k]),
      .e_i   (e_c[k]),
      .f_i   (f_c[k]),
      .q_i   (q_c[k]),
      .v_o   (v_c[k+1]),
      .s_o   (s_c[k+1]),
      .deg_o (deg_c[k+1]),
      .neg_o (neg_c[k+1]),
      .e_o   (e_c[k+1]),
      .f_o   (f_c[k+1]),
      .q_o   (q_c[k+1])
    );
  end

  // sign opposite to the cross component, zero for a degenerate triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (deg_c[NS-1]) begin
        n_nxt[i] = '0;
      end else if (neg_c[NS-1][i]) begin
        n_nxt[i] = NW'(q_c[NS-1][i]);
      end else begin
        n_nxt[i] = NW'(-NW'(q_c[NS-1][i]));
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_c[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      deg_r <= deg_c[NS-1];
    end
  end

  assign out_valid      = out_v_r;
  assign out_nx         = n_r[0];
  assign out_ny         = n_r[1];
  assign out_nz         = n_r[2];
  assign out_degenerate = deg_r;

endmodule
